>>> rtl/vslw_pkg.sv
// ----------------------------------------------------------------------------
// vslw_pkg: shared types and constants of the velocity slew limiter
// Field widths, operation and register codes, and the fixed-point helpers
// for the magnitude clamp, the slew step and the divide by one million.
// ----------------------------------------------------------------------------
package vslw_pkg;

   localparam int SPEED_W    = 24;
   localparam int LIMIT_W    = 23;
   localparam int ACCEL_W    = 24;
   localparam int TIME_W     = 24;
   localparam int DT_W       = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // accel * dt, then divided by 1e6 as (x >> 6) / 15625
   localparam int PROD_W     = ACCEL_W + DT_W;
   localparam int PRE_SHIFT  = 6;
   localparam int QUOT_W     = PROD_W - PRE_SHIFT;
   localparam int STEP_W     = 21;
   localparam int HIGH_SHIFT = 14;
   localparam int RECIP_SHIFT = 22;
   localparam int RECIP_W    = 23;
   localparam int EST_PROD_W = (QUOT_W - HIGH_SHIFT) + RECIP_W;
   localparam int DIV_ODD_FACTOR = 15625;
   // floor(2^36 / 15625)
   localparam int RECIP_MULT = 4398046;

   localparam logic [DT_W-1:0]   DT_LIMIT_US = 17'd100000;
   localparam logic [TIME_W-1:0] AGE_MAX     = {TIME_W{1'b1}};

   typedef enum logic {
      OP_COMMAND = 1'b0,
      OP_TICK    = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_LINEAR_SPEED  = 3'd0,
      CSR_MAX_ANGULAR_SPEED = 3'd1,
      CSR_MAX_LINEAR_ACCEL  = 3'd2,
      CSR_MAX_ANGULAR_ACCEL = 3'd3,
      CSR_COMMAND_TIMEOUT   = 3'd4
   } csr_index_type;

   function automatic logic signed [SPEED_W-1:0] clamp_speed(
      input logic signed [SPEED_W-1:0] value,
      input logic [LIMIT_W-1:0]        limit
   );
      logic signed [SPEED_W:0] v_ext;
      logic signed [SPEED_W:0] lim_pos;
      logic signed [SPEED_W:0] lim_neg;
      v_ext   = {value[SPEED_W-1], value};
      lim_pos = {2'b00, limit};
      lim_neg = -lim_pos;
      if (v_ext > lim_pos) begin
         return lim_pos[SPEED_W-1:0];
      end else if (v_ext < lim_neg) begin
         return lim_neg[SPEED_W-1:0];
      end else begin
         return value;
      end
   endfunction

   // move cur toward tgt by at most step; result lies between the two
   function automatic logic signed [SPEED_W-1:0] slew_toward(
      input logic signed [SPEED_W-1:0] cur,
      input logic signed [SPEED_W-1:0] tgt,
      input logic [STEP_W-1:0]         step
   );
      logic signed [SPEED_W:0] cur_ext;
      logic signed [SPEED_W:0] tgt_ext;
      logic signed [SPEED_W:0] diff;
      logic signed [SPEED_W:0] step_pos;
      logic signed [SPEED_W:0] step_neg;
      logic signed [SPEED_W:0] moved;
      cur_ext  = {cur[SPEED_W-1], cur};
      tgt_ext  = {tgt[SPEED_W-1], tgt};
      diff     = tgt_ext - cur_ext;
      step_pos = {{(SPEED_W + 1 - STEP_W){1'b0}}, step};
      step_neg = -step_pos;
      if (diff > step_pos) begin
         moved = cur_ext + step_pos;
      end else if (diff < step_neg) begin
         moved = cur_ext + step_neg;
      end else begin
         moved = tgt_ext;
      end
      return moved[SPEED_W-1:0];
   endfunction

   // low estimate of quot / 15625, at most two short of the true quotient
   function automatic logic [STEP_W-1:0] estimate_quotient(
      input logic [QUOT_W-1:0] quot
   );
      logic [EST_PROD_W-1:0] prod;
      prod = EST_PROD_W'(quot[QUOT_W-1:HIGH_SHIFT]) * EST_PROD_W'(RECIP_MULT);
      return prod[RECIP_SHIFT+STEP_W-1:RECIP_SHIFT];
   endfunction

   function automatic logic [STEP_W-1:0] finish_quotient(
      input logic [QUOT_W-1:0] quot,
      input logic [STEP_W-1:0] est
   );
      logic [QUOT_W-1:0] back;
      logic [QUOT_W-1:0] rem;
      back = QUOT_W'(est) * QUOT_W'(DIV_ODD_FACTOR);
      rem  = quot - back;
      if (rem >= QUOT_W'(2 * DIV_ODD_FACTOR)) begin
         return est + STEP_W'(2);
      end else if (rem >= QUOT_W'(DIV_ODD_FACTOR)) begin
         return est + STEP_W'(1);
      end else begin
         return est;
      end
   endfunction

endpackage

>>> rtl/velocity_slew_limiter_watchdog.sv
// ----------------------------------------------------------------------------
// velocity_slew_limiter_watchdog: two-channel velocity slew limiter
// Clamps commanded speeds, zeroes the outputs at once on a stale command and
// ramps the outputs toward the targets at the configured acceleration.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction | beat
//  req     | req_valid / req_stall + fields     | in        | command or tick
//  rsp     | rsp_valid / rsp_stall + fields     | out       | one per tick
//  csr     | csr_write_en, csr_index, csr_wdata | in        | register write
//
//  one beat per cycle unless rsp_stall holds a tick in the last stage
//  stages: input reg, accel*dt multiply, reciprocal estimate, quotient fix,
//  then state update into the result register
//  reset clears pipeline valids, state and loads register defaults
//  rsp_stall holds only a tick in the last stage; empty stages keep accepting
// ----------------------------------------------------------------------------
module velocity_slew_limiter_watchdog (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_operation,
   input  logic signed [vslw_pkg::SPEED_W-1:0]   req_linear_request,
   input  logic signed [vslw_pkg::SPEED_W-1:0]   req_angular_request,
   input  logic        [vslw_pkg::TIME_W-1:0]    req_elapsed_us,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [vslw_pkg::SPEED_W-1:0]   rsp_linear_out,
   output logic signed [vslw_pkg::SPEED_W-1:0]   rsp_angular_out,
   output logic                                  rsp_stale,
   output logic                                  rsp_stopped,
   input  logic                                  csr_write_en,
   input  logic        [vslw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [vslw_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import vslw_pkg::*;

   // configuration
   logic [LIMIT_W-1:0] max_lin_speed_ff;
   logic [LIMIT_W-1:0] max_ang_speed_ff;
   logic [ACCEL_W-1:0] max_lin_accel_ff;
   logic [ACCEL_W-1:0] max_ang_accel_ff;
   logic [TIME_W-1:0]  timeout_ff;

   // block state
   logic signed [SPEED_W-1:0] target_lin_ff, target_lin_in;
   logic signed [SPEED_W-1:0] target_ang_ff, target_ang_in;
   logic signed [SPEED_W-1:0] current_lin_ff, current_lin_in;
   logic signed [SPEED_W-1:0] current_ang_ff, current_ang_in;
   logic                      command_seen_ff, command_seen_in;
   logic [TIME_W-1:0]         age_ff, age_in;

   // pipeline stages
   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic v0_in, v1_in, v2_in, v3_in;
   op_type op0_ff, op1_ff, op2_ff, op3_ff;
   logic signed [SPEED_W-1:0] lin0_ff, lin1_ff, lin2_ff, lin3_ff;
   logic signed [SPEED_W-1:0] ang0_ff, ang1_ff, ang2_ff, ang3_ff;
   logic [TIME_W-1:0] elapsed0_ff, elapsed1_ff, elapsed2_ff, elapsed3_ff;
   logic [DT_W-1:0]   dt0;
   logic [PROD_W-1:0] prod_lin1_ff, prod_ang1_ff;
   logic [QUOT_W-1:0] quot_lin2_ff, quot_ang2_ff;
   logic [STEP_W-1:0] est_lin2_ff, est_ang2_ff;
   logic [STEP_W-1:0] step_lin3_ff, step_ang3_ff;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SPEED_W-1:0] rsp_lin_ff, rsp_lin_in;
   logic signed [SPEED_W-1:0] rsp_ang_ff, rsp_ang_in;
   logic                      rsp_stale_ff, rsp_stale_in;
   logic                      rsp_stopped_ff, rsp_stopped_in;

   logic out_free;
   logic go0, go1, go2, go3;
   logic free0, free1, free2, free3;
   logic accept;
   logic tick3;
   logic [TIME_W:0] age_sum;

   // ---------------- flow control ----------------
   always_comb begin
      tick3    = (op3_ff == OP_TICK);
      out_free = !rsp_valid_ff || !rsp_stall;
      go3      = v3_ff && (!tick3 || out_free);
      free3    = !v3_ff || go3;
      go2      = v2_ff && free3;
      free2    = !v2_ff || go2;
      go1      = v1_ff && free2;
      free1    = !v1_ff || go1;
      go0      = v0_ff && free1;
      free0    = !v0_ff || go0;
      accept   = req_valid && free0;
      v0_in    = accept || (v0_ff && !go0);
      v1_in    = go0 || (v1_ff && !go1);
      v2_in    = go1 || (v2_ff && !go2);
      v3_in    = go2 || (v3_ff && !go3);
      rsp_valid_in = (go3 && tick3) || (rsp_valid_ff && rsp_stall);
   end

   assign req_stall = !free0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v0_ff        <= v0_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         max_lin_speed_ff <= LIMIT_W'(150000);
         max_ang_speed_ff <= LIMIT_W'(800000);
         max_lin_accel_ff <= ACCEL_W'(300000);
         max_ang_accel_ff <= ACCEL_W'(1500000);
         timeout_ff       <= TIME_W'(500000);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MAX_LINEAR_SPEED:  max_lin_speed_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_MAX_ANGULAR_SPEED: max_ang_speed_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_MAX_LINEAR_ACCEL:  max_lin_accel_ff <= csr_wdata[ACCEL_W-1:0];
            CSR_MAX_ANGULAR_ACCEL: max_ang_accel_ff <= csr_wdata[ACCEL_W-1:0];
            CSR_COMMAND_TIMEOUT:   timeout_ff       <= csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- step pipeline ----------------
   assign dt0 = (elapsed0_ff < TIME_W'(DT_LIMIT_US)) ? elapsed0_ff[DT_W-1:0] : DT_LIMIT_US;

   always_ff @(posedge clock) begin
      if (accept) begin
         op0_ff      <= op_type'(req_operation);
         lin0_ff     <= req_linear_request;
         ang0_ff     <= req_angular_request;
         elapsed0_ff <= req_elapsed_us;
      end
      if (go0) begin
         op1_ff       <= op0_ff;
         lin1_ff      <= lin0_ff;
         ang1_ff      <= ang0_ff;
         elapsed1_ff  <= elapsed0_ff;
         prod_lin1_ff <= PROD_W'(max_lin_accel_ff) * PROD_W'(dt0);
         prod_ang1_ff <= PROD_W'(max_ang_accel_ff) * PROD_W'(dt0);
      end
      if (go1) begin
         op2_ff       <= op1_ff;
         lin2_ff      <= lin1_ff;
         ang2_ff      <= ang1_ff;
         elapsed2_ff  <= elapsed1_ff;
         quot_lin2_ff <= prod_lin1_ff[PROD_W-1:PRE_SHIFT];
         quot_ang2_ff <= prod_ang1_ff[PROD_W-1:PRE_SHIFT];
         est_lin2_ff  <= estimate_quotient(prod_lin1_ff[PROD_W-1:PRE_SHIFT]);
         est_ang2_ff  <= estimate_quotient(prod_ang1_ff[PROD_W-1:PRE_SHIFT]);
      end
      if (go2) begin
         op3_ff       <= op2_ff;
         lin3_ff      <= lin2_ff;
         ang3_ff      <= ang2_ff;
         elapsed3_ff  <= elapsed2_ff;
         step_lin3_ff <= finish_quotient(quot_lin2_ff, est_lin2_ff);
         step_ang3_ff <= finish_quotient(quot_ang2_ff, est_ang2_ff);
      end
   end

   // ---------------- state update ----------------
   always_comb begin
      logic                      timed;
      logic                      stop;
      logic signed [SPEED_W-1:0] tgt_l;
      logic signed [SPEED_W-1:0] tgt_a;
      target_lin_in    = target_lin_ff;
      target_ang_in    = target_ang_ff;
      current_lin_in   = current_lin_ff;
      current_ang_in   = current_ang_ff;
      command_seen_in  = command_seen_ff;
      age_in           = age_ff;
      rsp_lin_in       = rsp_lin_ff;
      rsp_ang_in       = rsp_ang_ff;
      rsp_stale_in     = rsp_stale_ff;
      rsp_stopped_in   = rsp_stopped_ff;
      age_sum          = {1'b0, age_ff} + {1'b0, elapsed3_ff};
      timed            = 1'b0;
      stop             = 1'b0;
      tgt_l            = target_lin_ff;
      tgt_a            = target_ang_ff;
      if (go3) begin
         if (!tick3) begin
            target_lin_in   = clamp_speed(lin3_ff, max_lin_speed_ff);
            target_ang_in   = clamp_speed(ang3_ff, max_ang_speed_ff);
            command_seen_in = 1'b1;
            age_in          = '0;
         end else begin
            age_in = age_sum[TIME_W] ? AGE_MAX : age_sum[TIME_W-1:0];
            timed  = !command_seen_ff || (age_in >= timeout_ff);
            if (timed) begin
               tgt_l = '0;
               tgt_a = '0;
            end
            stop = (tgt_l == '0) && (tgt_a == '0);
            target_lin_in = tgt_l;
            target_ang_in = tgt_a;
            if (stop) begin
               current_lin_in = '0;
               current_ang_in = '0;
            end else begin
               current_lin_in = slew_toward(current_lin_ff, tgt_l, step_lin3_ff);
               current_ang_in = slew_toward(current_ang_ff, tgt_a, step_ang3_ff);
            end
            rsp_lin_in       = current_lin_in;
            rsp_ang_in       = current_ang_in;
            rsp_stale_in     = timed;
            rsp_stopped_in   = stop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_lin_ff   <= '0;
         target_ang_ff   <= '0;
         current_lin_ff  <= '0;
         current_ang_ff  <= '0;
         command_seen_ff <= 1'b0;
         age_ff          <= '0;
      end else begin
         target_lin_ff   <= target_lin_in;
         target_ang_ff   <= target_ang_in;
         current_lin_ff  <= current_lin_in;
         current_ang_ff  <= current_ang_in;
         command_seen_ff <= command_seen_in;
         age_ff          <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_lin_ff       <= rsp_lin_in;
      rsp_ang_ff       <= rsp_ang_in;
      rsp_stale_ff     <= rsp_stale_in;
      rsp_stopped_ff   <= rsp_stopped_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_linear_out  = rsp_lin_ff;
   assign rsp_angular_out = rsp_ang_ff;
   assign rsp_stale       = rsp_stale_ff;
   assign rsp_stopped     = rsp_stopped_ff;

`ifndef NO_ASSERTIONS
   a_stopped_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stopped_ff) |-> (rsp_lin_ff == '0 && rsp_ang_ff == '0))
      else $error("stopped beat with nonzero speed");

   a_timeout_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stale_ff) |-> rsp_stopped_ff)
      else $error("stale beat not stopped");

   a_tick_held: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && tick3 && rsp_valid_ff && rsp_stall) |=> v3_ff)
      else $error("tick left last stage while result stalled");

   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !v0_ff |-> !req_stall)
      else $error("stall with empty input stage");

   a_command_seen: assert property (@(posedge clock) disable iff (reset)
      (go3 && !tick3) |=> (command_seen_ff && age_ff == '0))
      else $error("command did not arm watchdog");
`endif

endmodule
